// ===== rtl/core/diagonal_ramp_stepper_macros.svh =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper assertion macros
// Shared property wrappers, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DIAGONAL_RAMP_STEPPER_MACROS_SVH
`define DIAGONAL_RAMP_STEPPER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper package
// Item, result and register types, codes and the follow-step function.
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned RatioW = 24;
  localparam int unsigned GroupW = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    REG_LONG_START  = 3'd0,
    REG_LONG_FINAL  = 3'd1,
    REG_SHORT_START = 3'd2,
    REG_Z_START     = 3'd3,
    REG_STEP_SIZE   = 3'd4,
    REG_SHORT_RATIO = 3'd5,
    REG_Z_RATIO     = 3'd6,
    REG_MOVE_DELAY  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ValW-1:0]   long_start;
    logic [ValW-1:0]   long_final;
    logic [ValW-1:0]   short_start;
    logic [ValW-1:0]   z_start;
    logic [GroupW-1:0] step_size;
    logic [RatioW-1:0] short_ratio;
    logic [RatioW-1:0] z_ratio;
    logic [RatioW-1:0] move_delay;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    long_start:  '0,
    long_final:  '0,
    short_start: '0,
    z_start:     '0,
    step_size:   GroupW'(1),
    short_ratio: '0,
    z_ratio:     '0,
    move_delay:  '0
  };

  typedef struct packed {
    logic             action;
    logic [ChanW-1:0] short_channel;
    logic [ChanW-1:0] long_channel;
    logic             const_z;
    logic             z_up;
    logic             read_on;
    logic             long_up;
    logic             short_up;
  } in_item_t;

  typedef struct packed {
    logic const_z;
    logic z_up;
    logic read_on;
    logic long_up;
    logic short_up;
  } mode_t;

  typedef struct packed {
    logic             kind;
    logic [ChanW-1:0] long_dac_channel;
    logic [ChanW-1:0] short_dac_channel;
    logic [ValW-1:0]  long_value;
    logic [ValW-1:0]  short_value;
    logic [ValW-1:0]  z_value;
    logic             read_pulse;
    logic             done_res;
  } res_t;

  // move value one toward its direction while ratio * offset <= long offset
  function automatic logic [ValW-1:0] follow_step(
    input logic [ValW-1:0]   value,
    input logic [ValW-1:0]   start,
    input logic              up,
    input logic [RatioW-1:0] ratio,
    input logic [ValW-1:0]   loff
  );
    logic [ValW-1:0]        off;
    logic [RatioW+ValW-1:0] prod;
    logic [ValW-1:0]        res;
    off  = up ? (value - start) : (start - value);
    prod = (RatioW+ValW)'(ratio) * (RatioW+ValW)'(off);
    res  = value;
    if (prod <= (RatioW+ValW)'(loff)) begin
      res = up ? (value + ValW'(1)) : (value - ValW'(1));
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/drs_in_if.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper input channel
// Valid/ready channel carrying one start or tick item.
// ----------------------------------------------------------------------------
interface drs_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] short_channel;
  logic [3:0] long_channel;
  logic       const_z;
  logic       z_up;
  logic       read_on;
  logic       long_up;
  logic       short_up;

  modport source (
    output valid, action, short_channel, long_channel, const_z, z_up, read_on,
           long_up, short_up,
    input  ready
  );

  modport sink (
    input  valid, action, short_channel, long_channel, const_z, z_up, read_on,
           long_up, short_up,
    output ready
  );
endinterface

// ===== rtl/core/drs_out_if.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper output channel
// Valid/ready channel carrying one start or step result item.
// ----------------------------------------------------------------------------
interface drs_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  long_dac_channel;
  logic [3:0]  short_dac_channel;
  logic [15:0] long_value;
  logic [15:0] short_value;
  logic [15:0] z_value;
  logic        read_pulse;
  logic        done_res;

  modport source (
    output valid, kind, long_dac_channel, short_dac_channel, long_value,
           short_value, z_value, read_pulse, done_res,
    input  ready
  );

  modport sink (
    input  valid, kind, long_dac_channel, short_dac_channel, long_value,
           short_value, z_value, read_pulse, done_res,
    output ready
  );
endinterface

// ===== rtl/core/drs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper configuration registers
// APB register file for the ramp start and final values, ratios, group size and delay.
// ----------------------------------------------------------------------------
module drs_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [drs_pkg::AddrW-1:0]    paddr,
  input  logic [drs_pkg::DataW-1:0]    pwdata,
  output logic [drs_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  output drs_pkg::cfg_t                cfg_o
);
  import drs_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LONG_START:  cfg_d.long_start  = pwdata[ValW-1:0];
        REG_LONG_FINAL:  cfg_d.long_final  = pwdata[ValW-1:0];
        REG_SHORT_START: cfg_d.short_start = pwdata[ValW-1:0];
        REG_Z_START:     cfg_d.z_start     = pwdata[ValW-1:0];
        REG_STEP_SIZE:   cfg_d.step_size   = pwdata[GroupW-1:0];
        REG_SHORT_RATIO: cfg_d.short_ratio = pwdata[RatioW-1:0];
        REG_Z_RATIO:     cfg_d.z_ratio     = pwdata[RatioW-1:0];
        REG_MOVE_DELAY:  cfg_d.move_delay  = pwdata[RatioW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LONG_START:  prdata = DataW'(cfg_q.long_start);
      REG_LONG_FINAL:  prdata = DataW'(cfg_q.long_final);
      REG_SHORT_START: prdata = DataW'(cfg_q.short_start);
      REG_Z_START:     prdata = DataW'(cfg_q.z_start);
      REG_STEP_SIZE:   prdata = DataW'(cfg_q.step_size);
      REG_SHORT_RATIO: prdata = DataW'(cfg_q.short_ratio);
      REG_Z_RATIO:     prdata = DataW'(cfg_q.z_ratio);
      REG_MOVE_DELAY:  prdata = DataW'(cfg_q.move_delay);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/drs_step_core.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper step core
// Input register, ramp state, single-pass step logic and result register.
// ----------------------------------------------------------------------------
`include "diagonal_ramp_stepper_macros.svh"

module drs_step_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  drs_pkg::cfg_t cfg_i,
  drs_in_if.sink        in_if,
  drs_out_if.source     out_if
);
  import drs_pkg::*;

  logic              in_vld_q;
  in_item_t          in_q;
  logic              advance;

  logic              active_q, active_d;
  logic [ValW-1:0]   long_q, long_d;
  logic [ValW-1:0]   short_q, short_d;
  logic [ValW-1:0]   z_q, z_d;
  logic [GroupW-1:0] group_q, group_d;
  logic [RatioW-1:0] delay_q, delay_d;
  mode_t             mode_q, mode_d;
  logic [ChanW-1:0]  lchan_q, lchan_d;
  logic [ChanW-1:0]  schan_q, schan_d;

  logic              out_vld_q;
  res_t              out_q;
  res_t              res;
  logic              produce;

  logic [RatioW:0]   delay_inc;
  logic [ValW-1:0]   loff;
  logic [GroupW-1:0] group_inc;
  logic [GroupW-1:0] limit;

  assign advance  = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q <= '{action: in_if.action, short_channel: in_if.short_channel,
                long_channel: in_if.long_channel, const_z: in_if.const_z,
                z_up: in_if.z_up, read_on: in_if.read_on,
                long_up: in_if.long_up, short_up: in_if.short_up};
    end
  end

  assign delay_inc = {1'b0, delay_q} + (RatioW+1)'(1);
  assign loff      = mode_q.long_up ? (long_q - cfg_i.long_start)
                                    : (cfg_i.long_start - long_q);
  assign group_inc = group_q + GroupW'(1);
  assign limit     = (cfg_i.step_size == '0) ? GroupW'(1) : cfg_i.step_size;

  always_comb begin
    active_d = active_q;
    long_d   = long_q;
    short_d  = short_q;
    z_d      = z_q;
    group_d  = group_q;
    delay_d  = delay_q;
    mode_d   = mode_q;
    lchan_d  = lchan_q;
    schan_d  = schan_q;
    produce  = 1'b0;
    res      = '0;

    if (in_q.action == ACT_START) begin
      lchan_d  = in_q.long_channel;
      schan_d  = in_q.short_channel;
      mode_d   = '{const_z: in_q.const_z, z_up: in_q.z_up, read_on: in_q.read_on,
                   long_up: in_q.long_up, short_up: in_q.short_up};
      long_d   = cfg_i.long_start;
      short_d  = cfg_i.short_start;
      z_d      = cfg_i.z_start;
      group_d  = '0;
      delay_d  = '0;
      active_d = 1'b1;
      produce  = 1'b1;
      res.kind              = KIND_START;
      res.long_dac_channel  = in_q.long_channel;
      res.short_dac_channel = in_q.short_channel;
      res.long_value        = cfg_i.long_start;
      res.short_value       = cfg_i.short_start;
      res.z_value           = cfg_i.z_start;
    end else if (active_q) begin
      if (delay_inc < {1'b0, cfg_i.move_delay}) begin
        delay_d = delay_inc[RatioW-1:0];
      end else begin
        delay_d = '0;
        produce = 1'b1;
        short_d = follow_step(short_q, cfg_i.short_start, mode_q.short_up,
                              cfg_i.short_ratio, loff);
        if (!mode_q.const_z) begin
          z_d = follow_step(z_q, cfg_i.z_start, mode_q.z_up, cfg_i.z_ratio, loff);
        end
        res.kind              = KIND_STEP;
        res.long_dac_channel  = lchan_q;
        res.short_dac_channel = schan_q;
        res.long_value        = long_q;
        res.short_value       = short_d;
        res.z_value           = z_d;
        if (long_q == cfg_i.long_final) begin
          res.done_res = 1'b1;
          active_d     = 1'b0;
        end else begin
          long_d  = mode_q.long_up ? (long_q + ValW'(1)) : (long_q - ValW'(1));
          group_d = group_inc;
          if (group_inc >= limit || group_inc == '0) begin
            group_d        = '0;
            res.read_pulse = mode_q.read_on;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      long_q   <= '0;
      short_q  <= '0;
      z_q      <= '0;
      group_q  <= '0;
      delay_q  <= '0;
      mode_q   <= '0;
      lchan_q  <= '0;
      schan_q  <= '0;
    end else if (advance) begin
      active_q <= active_d;
      long_q   <= long_d;
      short_q  <= short_d;
      z_q      <= z_d;
      group_q  <= group_d;
      delay_q  <= delay_d;
      mode_q   <= mode_d;
      lchan_q  <= lchan_d;
      schan_q  <= schan_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && produce) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_q <= res;
    end
  end

  assign out_if.valid             = out_vld_q;
  assign out_if.kind              = out_q.kind;
  assign out_if.long_dac_channel  = out_q.long_dac_channel;
  assign out_if.short_dac_channel = out_q.short_dac_channel;
  assign out_if.long_value        = out_q.long_value;
  assign out_if.short_value       = out_q.short_value;
  assign out_if.z_value           = out_q.z_value;
  assign out_if.read_pulse        = out_q.read_pulse;
  assign out_if.done_res          = out_q.done_res;

  `DRS_ASSERT_SAME(a_start_flags, clk_i, rst_ni,
                   out_vld_q && out_q.kind == KIND_START,
                   !out_q.read_pulse && !out_q.done_res,
                   "start item carries a pulse or done flag")
  `DRS_ASSERT_SAME(a_pulse_done, clk_i, rst_ni, out_vld_q,
                   !(out_q.read_pulse && out_q.done_res),
                   "read pulse on a done step")
  `DRS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, advance && produce && res.done_res,
                   !active_q, "ramp still active after done step")
  `DRS_ASSERT_NEXT(a_start_load, clk_i, rst_ni, advance && in_q.action == ACT_START,
                   active_q && group_q == '0 && delay_q == '0,
                   "start item did not reload the ramp state")

endmodule

// ===== rtl/core/diagonal_ramp_stepper.sv =====
// ----------------------------------------------------------------------------
// Diagonal ramp stepper
// Steps a long DAC channel and lets a short channel and a z offset follow.
//
//   channel  | dir | handshake              | item
//   in_i     | in  | valid/ready            | start or microsecond tick
//   out_o    | out | valid/ready            | start value or ramp step
//   apb      | in  | psel/penable, pready=1 | configuration register access
//
// One item per cycle while the result is not stalled: input register, then
// one pass of step logic (two 24x16 multiply-compares) into the result
// register. Reset clears the ramp state; registers come up zero, step_size
// one. A waiting result holds while one more item waits in the input register.
// ----------------------------------------------------------------------------
module diagonal_ramp_stepper (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [drs_pkg::AddrW-1:0] paddr,
  input  logic [drs_pkg::DataW-1:0] pwdata,
  output logic [drs_pkg::DataW-1:0] prdata,
  output logic                      pready,
  drs_in_if.sink                    in_i,
  drs_out_if.source                 out_o
);
  import drs_pkg::*;

  cfg_t cfg;

  drs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  drs_step_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_i),
    .out_if (out_o)
  );

endmodule

// ===== sim/ramp_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramp stepper checker
// Mirrors the register file and the ramp state, works out the result item
// each accepted input item should cause, and checks returned items in order.
// ----------------------------------------------------------------------------
package ramp_check_pkg;
  import drs_pkg::*;

  class ramp_tracker;
    cfg_t              cfg;
    bit                active;
    logic [ValW-1:0]   cur_long;
    logic [ValW-1:0]   cur_short;
    logic [ValW-1:0]   cur_z;
    logic [GroupW-1:0] group_count;
    logic [RatioW-1:0] delay_count;
    mode_t             mode;
    logic [ChanW-1:0]  short_ch;
    logic [ChanW-1:0]  long_ch;
    res_t              due[$];
    int unsigned       failures;
    int unsigned       starts;
    int unsigned       steps;
    int unsigned       ramps_done;
    int unsigned       pulses;

    function new();
      cfg           = '0;
      cfg.step_size = GroupW'(1);
      active        = 1'b0;
      cur_long      = '0;
      cur_short     = '0;
      cur_z         = '0;
      group_count   = '0;
      delay_count   = '0;
      mode          = '0;
      short_ch      = '0;
      long_ch       = '0;
      failures      = 0;
      starts        = 0;
      steps         = 0;
      ramps_done    = 0;
      pulses        = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] v);
      case (idx)
        REG_LONG_START:  cfg.long_start  = v[ValW-1:0];
        REG_LONG_FINAL:  cfg.long_final  = v[ValW-1:0];
        REG_SHORT_START: cfg.short_start = v[ValW-1:0];
        REG_Z_START:     cfg.z_start     = v[ValW-1:0];
        REG_STEP_SIZE:   cfg.step_size   = v[GroupW-1:0];
        REG_SHORT_RATIO: cfg.short_ratio = v[RatioW-1:0];
        REG_Z_RATIO:     cfg.z_ratio     = v[RatioW-1:0];
        default:         cfg.move_delay  = v[RatioW-1:0];
      endcase
    endfunction

    function logic [DataW-1:0] reg_value(reg_idx_e idx);
      case (idx)
        REG_LONG_START:  return DataW'(cfg.long_start);
        REG_LONG_FINAL:  return DataW'(cfg.long_final);
        REG_SHORT_START: return DataW'(cfg.short_start);
        REG_Z_START:     return DataW'(cfg.z_start);
        REG_STEP_SIZE:   return DataW'(cfg.step_size);
        REG_SHORT_RATIO: return DataW'(cfg.short_ratio);
        REG_Z_RATIO:     return DataW'(cfg.z_ratio);
        default:         return DataW'(cfg.move_delay);
      endcase
    endfunction

    // advance one toward the direction while ratio * own offset <= long offset
    function logic [ValW-1:0] trail(logic [ValW-1:0] v, logic [ValW-1:0] origin,
                                    bit up, logic [RatioW-1:0] ratio,
                                    logic [ValW-1:0] loff);
      logic [ValW-1:0]        off;
      logic [RatioW+ValW-1:0] prod;
      off  = up ? v - origin : origin - v;
      prod = (RatioW+ValW)'(ratio) * (RatioW+ValW)'(off);
      if (prod <= (RatioW+ValW)'(loff)) begin
        v = up ? v + ValW'(1) : v - ValW'(1);
      end
      return v;
    endfunction

    // returns 0 for an item the block ignores
    function bit note_item(in_item_t it);
      res_t              r;
      logic [ValW-1:0]   loff;
      logic [GroupW-1:0] limit;
      r = '0;
      if (it.action == ACT_START) begin
        short_ch       = it.short_channel;
        long_ch        = it.long_channel;
        mode.const_z   = it.const_z;
        mode.z_up      = it.z_up;
        mode.read_on   = it.read_on;
        mode.long_up   = it.long_up;
        mode.short_up  = it.short_up;
        cur_long       = cfg.long_start;
        cur_short      = cfg.short_start;
        cur_z          = cfg.z_start;
        group_count    = '0;
        delay_count    = '0;
        active         = 1'b1;
        r.kind              = KIND_START;
        r.long_dac_channel  = long_ch;
        r.short_dac_channel = short_ch;
        r.long_value        = cur_long;
        r.short_value       = cur_short;
        r.z_value           = cur_z;
        due.push_back(r);
        return 1'b1;
      end
      if (!active) return 1'b0;
      if (32'(delay_count) + 32'd1 < 32'(cfg.move_delay)) begin
        delay_count = delay_count + RatioW'(1);
        return 1'b1;
      end
      delay_count  = '0;
      loff         = mode.long_up ? cur_long - cfg.long_start : cfg.long_start - cur_long;
      r.long_value = cur_long;
      cur_short = trail(cur_short, cfg.short_start, mode.short_up, cfg.short_ratio, loff);
      if (!mode.const_z) begin
        cur_z = trail(cur_z, cfg.z_start, mode.z_up, cfg.z_ratio, loff);
      end
      if (cur_long == cfg.long_final) begin
        r.done_res = 1'b1;
        active     = 1'b0;
      end else begin
        cur_long    = mode.long_up ? cur_long + ValW'(1) : cur_long - ValW'(1);
        limit       = (cfg.step_size == '0) ? GroupW'(1) : cfg.step_size;
        group_count = group_count + GroupW'(1);
        if (group_count >= limit || group_count == '0) begin
          group_count  = '0;
          r.read_pulse = mode.read_on;
        end
      end
      r.kind              = KIND_STEP;
      r.long_dac_channel  = long_ch;
      r.short_dac_channel = short_ch;
      r.short_value       = cur_short;
      r.z_value           = cur_z;
      due.push_back(r);
      return 1'b1;
    endfunction

    function void cmp(string field, logic [DataW-1:0] exp, logic [DataW-1:0] got);
      if (got !== exp) begin
        $error("%s: expected %0h, got %0h", field, exp, got);
        failures++;
      end
    endfunction

    function void check_readback(reg_idx_e idx, logic [DataW-1:0] got);
      cmp(idx.name(), reg_value(idx), got);
    endfunction

    function void check_step(res_t got);
      res_t exp;
      if (due.size() == 0) begin
        $error("result item with none expected: long_value %0h", got.long_value);
        failures++;
        return;
      end
      exp = due.pop_front();
      cmp("kind", DataW'(exp.kind), DataW'(got.kind));
      cmp("long_dac_channel", DataW'(exp.long_dac_channel), DataW'(got.long_dac_channel));
      cmp("short_dac_channel", DataW'(exp.short_dac_channel),
          DataW'(got.short_dac_channel));
      cmp("long_value", DataW'(exp.long_value), DataW'(got.long_value));
      cmp("short_value", DataW'(exp.short_value), DataW'(got.short_value));
      cmp("z_value", DataW'(exp.z_value), DataW'(got.z_value));
      cmp("read_pulse", DataW'(exp.read_pulse), DataW'(got.read_pulse));
      cmp("done_res", DataW'(exp.done_res), DataW'(got.done_res));
      if (exp.kind == KIND_START) starts++;
      else steps++;
      if (exp.done_res) ramps_done++;
      if (exp.read_pulse) pulses++;
    endfunction

    function int unsigned waiting();
      return due.size();
    endfunction

    function void flush();
      if (due.size() != 0) begin
        $error("%0d result items never arrived", due.size());
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_diagonal_ramp_stepper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Diagonal ramp stepper testbench
// Directed ramps over the register extremes, then random ramps, register
// changes mid-ramp and stray items, with bursty stalls on both channels.
// Every result item is checked against a cycle-free model of the ramp.
// ----------------------------------------------------------------------------
module tb_diagonal_ramp_stepper;
  import drs_pkg::*;
  import ramp_check_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic             pready;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;

  drs_in_if  in_if ();
  drs_out_if out_if ();

  ramp_tracker tracker = new();
  int unsigned live    = 0;
  int unsigned ignored = 0;
  int unsigned writes  = 0;
  bit          calm    = 1'b0;

  diagonal_ramp_stepper dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_if.ready = (stall_left == 0) && rst_n;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      tracker.check_step({out_if.kind, out_if.long_dac_channel, out_if.short_dac_channel,
                          out_if.long_value, out_if.short_value, out_if.z_value,
                          out_if.read_pulse, out_if.done_res});
    end
  end

  function automatic in_item_t any_item(action_e act);
    logic [31:0] raw;
    in_item_t    it;
    raw       = $urandom;
    it        = raw[$bits(in_item_t)-1:0];
    it.action = act;
    return it;
  endfunction

  function automatic logic [DataW-1:0] pick_reg(reg_idx_e idx);
    logic [DataW-1:0] v;
    logic [DataW-1:0] mask;
    case (idx)
      REG_STEP_SIZE: begin
        mask = 32'h0000_00FF;
        case ($urandom_range(0, 7))
          0:       v = 0;
          1:       v = 255;
          default: v = $urandom_range(1, 6);
        endcase
      end
      REG_MOVE_DELAY: begin
        mask = 32'h00FF_FFFF;
        case ($urandom_range(0, 15))
          0:          v = 32'h00FF_FFFF;
          1, 2, 3, 4: v = 0;
          default:    v = $urandom_range(1, 3);
        endcase
      end
      REG_SHORT_RATIO, REG_Z_RATIO: begin
        mask = 32'h00FF_FFFF;
        case ($urandom_range(0, 7))
          0, 1:    v = 0;
          2, 3, 4: v = $urandom_range(1, 4);
          5:       v = 32'h00FF_FFFF;
          default: v = $urandom;
        endcase
      end
      default: begin
        mask = 32'h0000_FFFF;
        case ($urandom_range(0, 3))
          0:       v = 0;
          1:       v = 32'h0000_FFFF - $urandom_range(0, 8);
          default: v = $urandom;
        endcase
      end
    endcase
    return (v & mask) | ($urandom & ~mask);
  endfunction

  task automatic push_item(in_item_t it);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_if.action        = it.action;
    in_if.short_channel = it.short_channel;
    in_if.long_channel  = it.long_channel;
    in_if.const_z       = it.const_z;
    in_if.z_up          = it.z_up;
    in_if.read_on       = it.read_on;
    in_if.long_up       = it.long_up;
    in_if.short_up      = it.short_up;
    in_if.valid         = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (tracker.note_item(it)) live++;
    else ignored++;
    @(negedge clk);
  endtask

  // drop valid and hold until every expected item is back and the pipe is empty
  task automatic settle();
    in_if.valid = 1'b0;
    while (tracker.waiting() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [DataW-1:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_reg(idx, v);
    writes++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.check_readback(idx, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_ramp();
    logic [ValW-1:0]   base;
    logic [ValW-1:0]   span;
    logic [RatioW-1:0] pace;
    logic [DataW-1:0]  v;
    bit                rise;
    int unsigned       ticks;
    in_item_t          it;
    v    = pick_reg(REG_LONG_START);
    base = v[ValW-1:0];
    span = ValW'($urandom_range(0, 24));
    rise = 1'($urandom_range(0, 1));
    cfg_write(REG_LONG_START, v);
    cfg_write(REG_LONG_FINAL, rise ? DataW'(base + span) : DataW'(base - span));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_SHORT_START, pick_reg(REG_SHORT_START));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_Z_START, pick_reg(REG_Z_START));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_STEP_SIZE, pick_reg(REG_STEP_SIZE));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_SHORT_RATIO, pick_reg(REG_SHORT_RATIO));
    if ($urandom_range(0, 3) != 0) cfg_write(REG_Z_RATIO, pick_reg(REG_Z_RATIO));
    v    = pick_reg(REG_MOVE_DELAY);
    pace = v[RatioW-1:0];
    cfg_write(REG_MOVE_DELAY, v);
    it         = any_item(ACT_START);
    it.long_up = rise;
    push_item(it);
    ticks = (span + 1) * ((pace == 0) ? 1 : pace) + $urandom_range(0, 3);
    if (ticks > 100) ticks = $urandom_range(20, 100);
    if ($urandom_range(0, 5) == 0) ticks = $urandom_range(0, ticks);
    repeat (ticks) push_item(any_item(ACT_TICK));
    settle();
  endtask

  // change registers under a running ramp, then keep it ticking
  task automatic nudge_ramp();
    reg_idx_e idx;
    repeat ($urandom_range(1, 2)) begin
      idx = reg_idx_e'($urandom_range(0, 7));
      cfg_write(idx, pick_reg(idx));
    end
    repeat ($urandom_range(5, 40)) push_item(any_item(ACT_TICK));
    settle();
  endtask

  task automatic scatter();
    repeat ($urandom_range(10, 30)) begin
      push_item(any_item(($urandom_range(0, 4) == 0) ? ACT_START : ACT_TICK));
    end
    settle();
  endtask

  initial begin
    in_item_t    it;
    int unsigned spin;
    in_if.valid         = 1'b0;
    in_if.action        = ACT_TICK;
    in_if.short_channel = '0;
    in_if.long_channel  = '0;
    in_if.const_z       = 1'b0;
    in_if.z_up          = 1'b0;
    in_if.read_on       = 1'b0;
    in_if.long_up       = 1'b0;
    in_if.short_up      = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    rst_n               = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset registers: tick while idle, zero-length ramp, tick after done
    push_item(any_item(ACT_TICK));
    it = '0;
    push_item(it);
    push_item(any_item(ACT_TICK));
    push_item(any_item(ACT_TICK));
    settle();

    // long wraps past the top to a final value behind it, short wraps too
    cfg_write(REG_LONG_START, 32'hA5A5_FFFD);
    cfg_write(REG_LONG_FINAL, 32'h0000_0002);
    cfg_write(REG_SHORT_START, 32'hFFFF_FFFF);
    cfg_write(REG_Z_START, 32'h1234_0000);
    cfg_write(REG_STEP_SIZE, 32'h0000_0102);
    cfg_write(REG_SHORT_RATIO, 32'h0000_0000);
    cfg_write(REG_Z_RATIO, 32'hFFFF_FFFF);
    cfg_write(REG_MOVE_DELAY, 32'h0000_0001);
    it         = '1;
    it.action  = ACT_START;
    it.const_z = 1'b0;
    it.z_up    = 1'b0;
    push_item(it);
    repeat (7) push_item(any_item(ACT_TICK));
    settle();

    // downward past zero, step size zero, constant z, restart while active
    cfg_write(REG_LONG_START, 32'h0000_0001);
    cfg_write(REG_LONG_FINAL, 32'h0000_FFFE);
    cfg_write(REG_STEP_SIZE, 32'h0000_0000);
    cfg_write(REG_SHORT_RATIO, 32'h00FF_FFFF);
    cfg_write(REG_Z_RATIO, 32'h0000_0000);
    cfg_write(REG_MOVE_DELAY, 32'h0000_0002);
    it         = '0;
    it.const_z = 1'b1;
    it.read_on = 1'b1;
    push_item(it);
    repeat (3) push_item(any_item(ACT_TICK));
    push_item(it);
    repeat (8) push_item(any_item(ACT_TICK));
    settle();

    while (live + ignored < 1050) begin
      if (live + ignored >= 900) calm = 1'b1;
      case ($urandom_range(0, 9))
        0, 1:    nudge_ramp();
        2, 3:    scatter();
        default: run_ramp();
      endcase
    end

    spin = 0;
    while (tracker.waiting() != 0 && spin < 5000) begin
      @(posedge clk);
      spin++;
    end
    repeat (8) @(posedge clk);
    tracker.flush();

    $display("Sent %0d items (%0d more ticks while idle) and %0d register writes.",
             live, ignored, writes);
    $display("Checked %0d start and %0d step items; %0d ramps finished, %0d read pulses.",
             tracker.starts, tracker.steps, tracker.ramps_done, tracker.pulses);
    if (tracker.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
